// ===== hw/rtl/fcla_pkg.sv =====
// Shared types, constants and helpers for the fragment chain local aligner.
package fcla_pkg;

  // Accumulator width for chain plus gap cost before saturation
  localparam int ACC_W = 40;

  // Configuration register indexes
  localparam logic [1:0] REG_ROW_OPEN   = 2'd0;
  localparam logic [1:0] REG_ROW_EXTEND = 2'd1;
  localparam logic [1:0] REG_COL_OPEN   = 2'd2;
  localparam logic [1:0] REG_COL_EXTEND = 2'd3;

  typedef enum logic [7:0] {
    ST_LOAD      = 8'b0000_0001,
    ST_SCAN      = 8'b0000_0010,
    ST_TOTAL     = 8'b0000_0100,
    ST_WRITE     = 8'b0000_1000,
    ST_NEXT      = 8'b0001_0000,
    ST_TRACE_RD  = 8'b0010_0000,
    ST_TRACE_LD  = 8'b0100_0000,
    ST_TRACE_OUT = 8'b1000_0000
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic start_set;
    logic scan_start;
    logic advance;
    logic total;
    logic write;
    logic trace_init;
    logic trace_rd;
    logic trace_load;
    logic load_none;
    logic clear;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_done;
    logic first;
    logic next_found;
    logic best_valid;
    logic out_last;
  } sts_t;

  // Saturate an accumulator value to 32-bit signed
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = $signed({{(ACC_W-32){1'b0}}, 32'h7fff_ffff});
    lo = $signed({{(ACC_W-32){1'b1}}, 32'h8000_0000});
    if (v > hi) begin
      return 32'sh7fff_ffff;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// ===== hw/rtl/fragment_chain_local_aligner_unit.sv =====
// Fragment chain local aligner: stores up to MAX_FRAGMENTS fragments, then finds and
// traces the best local chain. Loading takes one word per cycle. After the final
// word, each of the n stored fragments (plus one initial ordering pass) costs one
// scan of the fragment memory at one entry per cycle, through its single read port,
// followed by the pipeline drain and the chain update. The trace then issues each
// result word through a read, a load and an output state while the output is taken;
// no input is accepted from the final fragment until the last result word has been
// taken.
module fragment_chain_local_aligner_unit #(
  parameter int MAX_FRAGMENTS = 64,
  parameter int POS_WIDTH     = 16
) (
  input  logic        clk,
  input  logic        rst,
  // row_start, row_end, col_start, col_end, frag_score
  input  logic [79:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic        s_tlast,
  // fragment_index, chain_score, zero pad
  output logic [39:0] m_tdata,
  // chain_found, overflowed
  output logic [1:0]  m_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  fcla_pkg::cmd_t cmd;
  fcla_pkg::sts_t sts;
  logic [5:0]     fragment_index;
  logic [30:0]    chain_score;
  logic           chain_found;
  logic           overflowed;

  fcla_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_last  (s_tlast),
    .s_ready (s_tready),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .cmd     (cmd),
    .sts     (sts)
  );

  fcla_dp #(
    .MAX_FRAGMENTS (MAX_FRAGMENTS),
    .POS_WIDTH     (POS_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .row_start      (s_tdata[15:0]),
    .row_end        (s_tdata[31:16]),
    .col_start      (s_tdata[47:32]),
    .col_end        (s_tdata[63:48]),
    .frag_score     (s_tdata[79:64]),
    .fragment_index (fragment_index),
    .chain_score    (chain_score),
    .chain_found    (chain_found),
    .overflowed     (overflowed),
    .last_of_run    (m_tlast)
  );

  assign m_tdata = {3'b000, chain_score, fragment_index};
  assign m_tuser = {overflowed, chain_found};

  // Input and output never open together
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input open while result pending");

  // After the last result word, loading resumes
  a_resume: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready) else $error("no return to loading");

  // A no-chain result is a single word with a zero index and a zero score
  a_no_chain: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tlast && (m_tdata[36:0] == 37'd0)))
    else $error("bad no-chain result");

endmodule

// ===== hw/rtl/fcla_ctrl.sv =====
// Controller state machine: sequences loading, chain scans and trace output.
module fcla_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_valid,
  input  logic              s_last,
  output logic              s_ready,
  output logic              m_valid,
  input  logic              m_ready,
  output fcla_pkg::cmd_t    cmd,
  input  fcla_pkg::sts_t    sts
);

  fcla_pkg::state_t state;
  fcla_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcla_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_ready    = 1'b0;
    m_valid    = 1'b0;
    case (state)
      fcla_pkg::ST_LOAD: begin
        s_ready = 1'b1;
        if (s_valid) begin
          cmd.load = 1'b1;
          if (s_last) begin
            cmd.start_set  = 1'b1;
            cmd.scan_start = 1'b1;
            state_next     = fcla_pkg::ST_SCAN;
          end
        end
      end
      fcla_pkg::ST_SCAN: begin
        if (sts.scan_done) begin
          state_next = sts.first ? fcla_pkg::ST_NEXT : fcla_pkg::ST_TOTAL;
        end
      end
      fcla_pkg::ST_TOTAL: begin
        cmd.total  = 1'b1;
        state_next = fcla_pkg::ST_WRITE;
      end
      fcla_pkg::ST_WRITE: begin
        cmd.write  = 1'b1;
        state_next = fcla_pkg::ST_NEXT;
      end
      fcla_pkg::ST_NEXT: begin
        if (sts.next_found) begin
          cmd.advance    = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = fcla_pkg::ST_SCAN;
        end else if (sts.best_valid) begin
          cmd.trace_init = 1'b1;
          state_next     = fcla_pkg::ST_TRACE_RD;
        end else begin
          cmd.load_none = 1'b1;
          state_next    = fcla_pkg::ST_TRACE_OUT;
        end
      end
      fcla_pkg::ST_TRACE_RD: begin
        cmd.trace_rd = 1'b1;
        state_next   = fcla_pkg::ST_TRACE_LD;
      end
      fcla_pkg::ST_TRACE_LD: begin
        cmd.trace_load = 1'b1;
        state_next     = fcla_pkg::ST_TRACE_OUT;
      end
      fcla_pkg::ST_TRACE_OUT: begin
        m_valid = 1'b1;
        if (m_ready) begin
          if (sts.out_last) begin
            cmd.clear  = 1'b1;
            state_next = fcla_pkg::ST_LOAD;
          end else begin
            state_next = fcla_pkg::ST_TRACE_RD;
          end
        end
      end
      default: begin
        state_next = fcla_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

// ===== hw/rtl/fcla_dp.sv =====
// Datapath: fragment and chain memories, scan pipeline, best tracking, output register.
module fcla_dp #(
  parameter int MAX_FRAGMENTS = 64,
  parameter int POS_WIDTH     = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  fcla_pkg::cmd_t      cmd,
  output fcla_pkg::sts_t      sts,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [15:0]         row_start,
  input  logic [15:0]         row_end,
  input  logic [15:0]         col_start,
  input  logic [15:0]         col_end,
  input  logic signed [15:0]  frag_score,
  output logic [5:0]          fragment_index,
  output logic [30:0]         chain_score,
  output logic                chain_found,
  output logic                overflowed,
  output logic                last_of_run
);

  localparam int PW    = (POS_WIDTH < 16) ? POS_WIDTH : 16;
  localparam int IW    = $clog2(MAX_FRAGMENTS);
  localparam int CW    = $clog2(MAX_FRAGMENTS + 1);
  localparam int FW    = 4 * PW + 16;
  localparam int CMW   = 1 + IW + 32;
  localparam int PRW   = PW + 17;
  localparam int ACC_W = fcla_pkg::ACC_W;

  // Gap cost registers
  logic signed [15:0] row_open, row_ext, col_open, col_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_open <= '0;
      row_ext  <= '0;
      col_open <= '0;
      col_ext  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fcla_pkg::REG_ROW_OPEN:   row_open <= cfg_data;
        fcla_pkg::REG_ROW_EXTEND: row_ext  <= cfg_data;
        fcla_pkg::REG_COL_OPEN:   col_open <= cfg_data;
        fcla_pkg::REG_COL_EXTEND: col_ext  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Memories
  logic [FW-1:0]  frag_mem  [MAX_FRAGMENTS];
  logic [CMW-1:0] chain_mem [MAX_FRAGMENTS];
  logic [FW-1:0]  fm_q;
  logic [CMW-1:0] cm_q;

  // Load counter and overflow flag
  logic [CW-1:0] count;
  logic          ovf;
  logic          room;
  assign room = count < CW'(MAX_FRAGMENTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.clear) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.load) begin
      if (room) begin
        count <= count + 1'b1;
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      frag_mem[count[IW-1:0]] <= {frag_score, col_end[PW-1:0], col_start[PW-1:0],
                                  row_end[PW-1:0], row_start[PW-1:0]};
    end
  end

  // Current fragment i under evaluation
  logic [IW-1:0]      idx_i;
  logic [PW-1:0]      rs_i, cs_i;
  logic signed [15:0] own_i;
  logic               first;

  // Scan counter
  logic          scan_act;
  logic [CW-1:0] j;
  logic          issue;
  assign issue = scan_act && (j < count);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_act <= 1'b0;
      j        <= '0;
    end else if (cmd.scan_start) begin
      scan_act <= 1'b1;
      j        <= '0;
    end else if (scan_act) begin
      j <= j + 1'b1;
      if (({1'b0, j} + 1'b1) >= {1'b0, count}) begin
        scan_act <= 1'b0;
      end
    end
  end

  // Trace cursor and chain memory read address
  logic [IW-1:0] cur_t;
  logic [IW-1:0] caddr;
  assign caddr = cmd.trace_rd ? cur_t : j[IW-1:0];

  // Chain record written for i
  logic signed [31:0] total_q;
  logic               has;
  logic [IW-1:0]      best_pred;

  always_ff @(posedge clk) begin
    fm_q <= frag_mem[j[IW-1:0]];
    cm_q <= chain_mem[caddr];
    if (cmd.write) begin
      if (total_q < 0) begin
        chain_mem[idx_i] <= '0;
      end else begin
        chain_mem[idx_i] <= {has, best_pred, total_q};
      end
    end
  end

  // Stage 1: qualify predecessor, form gap distances and products
  logic          v1;
  logic [IW-1:0] j1;
  logic [PW-1:0] rs_j, re_j, cs_j, ce_j;
  logic signed [15:0] own_j;
  logic signed [31:0] chain_j;
  logic          prec, ok1, aft;
  logic [PW-1:0] dr, dc;
  logic signed [PRW-1:0] prod_r, prod_c;

  assign rs_j    = fm_q[PW-1:0];
  assign re_j    = fm_q[2*PW-1:PW];
  assign cs_j    = fm_q[3*PW-1:2*PW];
  assign ce_j    = fm_q[4*PW-1:3*PW];
  assign own_j   = fm_q[FW-1:4*PW];
  assign chain_j = cm_q[31:0];
  assign prec    = (rs_j < rs_i) || ((rs_j == rs_i) && (j1 < idx_i));
  assign ok1     = !first && prec && (re_j < rs_i) && (ce_j < cs_i) && (chain_j > 0);
  assign aft     = first || (rs_j > rs_i) || ((rs_j == rs_i) && (j1 > idx_i));
  assign dr      = rs_i - re_j;
  assign dc      = cs_i - ce_j;
  assign prod_r  = $signed({1'b0, dr}) * row_ext;
  assign prod_c  = $signed({1'b0, dc}) * col_ext;

  logic                  v2, ok2, drb2, dcb2;
  logic signed [PRW-1:0] prod_r2, prod_c2;
  logic signed [31:0]    chain2;
  logic [PW-1:0]         ce2;
  logic [IW-1:0]         j2;

  // Stage 2: gap cost plus predecessor chain
  logic signed [ACC_W-1:0] term_r, term_c, sum2;
  assign term_r = drb2 ? (ACC_W'(row_open) + ACC_W'(prod_r2)) : '0;
  assign term_c = dcb2 ? (ACC_W'(col_open) + ACC_W'(prod_c2)) : '0;
  assign sum2   = ACC_W'(chain2) + term_r + term_c;

  logic                    v3, ok3;
  logic signed [ACC_W-1:0] sum3;
  logic [PW-1:0]           ce3;
  logic [IW-1:0]           j3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
    end
    j1      <= j[IW-1:0];
    ok2     <= ok1;
    drb2    <= dr > PW'(1);
    dcb2    <= dc > PW'(1);
    prod_r2 <= prod_r;
    prod_c2 <= prod_c;
    chain2  <= chain_j;
    ce2     <= ce_j;
    j2      <= j1;
    ok3     <= ok2;
    sum3    <= sum2;
    ce3     <= ce2;
    j3      <= j2;
  end

  // Stage 3: saturate candidate and keep the best
  logic signed [31:0] cand, best;
  logic [PW-1:0]      best_col;
  logic               take;
  assign cand = fcla_pkg::sat32(sum3);
  assign take = v3 && ok3 && (cand >= best) &&
                (!has || (cand > best) || (ce3 > best_col) ||
                 ((ce3 == best_col) && (j3 > best_pred)));

  always_ff @(posedge clk) begin
    if (rst) begin
      has <= 1'b0;
    end else if (cmd.scan_start) begin
      has <= 1'b0;
    end else if (take) begin
      has <= 1'b1;
    end
    if (cmd.scan_start) begin
      best <= '0;
    end else if (take) begin
      best      <= cand;
      best_pred <= j3;
      best_col  <= ce3;
    end
  end

  // Next fragment in processing order, found during the same scan
  logic               nf;
  logic [IW-1:0]      nidx;
  logic [PW-1:0]      nrs, ncs;
  logic signed [15:0] nown;

  always_ff @(posedge clk) begin
    if (rst) begin
      nf <= 1'b0;
    end else if (cmd.scan_start) begin
      nf <= 1'b0;
    end else if (v1 && aft && (!nf || (rs_j < nrs))) begin
      nf <= 1'b1;
    end
    if (v1 && aft && (!nf || (rs_j < nrs))) begin
      nidx <= j1;
      nrs  <= rs_j;
      ncs  <= cs_j;
      nown <= own_j;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first <= 1'b1;
    end else if (cmd.start_set) begin
      first <= 1'b1;
    end else if (cmd.advance) begin
      first <= 1'b0;
    end
    if (cmd.advance) begin
      idx_i <= nidx;
      rs_i  <= nrs;
      cs_i  <= ncs;
      own_i <= nown;
    end
  end

  // Chain total for i and global best end
  logic signed [31:0] gbest;
  logic [IW-1:0]      gend;
  logic               gvalid;

  always_ff @(posedge clk) begin
    if (cmd.total) begin
      total_q <= has ? fcla_pkg::sat32(ACC_W'(best) + ACC_W'(own_i)) : 32'(own_i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gvalid <= 1'b0;
      gbest  <= '0;
    end else if (cmd.start_set) begin
      gvalid <= 1'b0;
      gbest  <= '0;
    end else if (cmd.write && (total_q > gbest)) begin
      gvalid <= 1'b1;
      gbest  <= total_q;
      gend   <= idx_i;
    end
  end

  // Trace walk and output word register
  always_ff @(posedge clk) begin
    if (cmd.trace_init) begin
      cur_t <= gend;
    end else if (cmd.trace_load) begin
      cur_t <= cm_q[CMW-2:32];
    end
    if (cmd.trace_load) begin
      fragment_index <= 6'(cur_t);
      chain_score    <= gbest[30:0];
      chain_found    <= 1'b1;
      overflowed     <= ovf;
      last_of_run    <= !cm_q[CMW-1];
    end else if (cmd.load_none) begin
      fragment_index <= '0;
      chain_score    <= '0;
      chain_found    <= 1'b0;
      overflowed     <= ovf;
      last_of_run    <= 1'b1;
    end
  end

  assign sts.scan_done  = !scan_act && !v1 && !v2 && !v3;
  assign sts.first      = first;
  assign sts.next_found = nf;
  assign sts.best_valid = gvalid;
  assign sts.out_last   = last_of_run;

endmodule
